### sv/hbd_pkg.sv
// hbd_pkg: shared types and constants for the http body deframer
// no dependencies; imported by every module of the block
`default_nettype none

package hbd_pkg;

  localparam int LENGTH_BITS = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic       CFG_FRAMING_MODE    = 1'b0;
  localparam logic       CFG_EXPECTED_LENGTH = 1'b1;
  localparam logic       ACT_DATA            = 1'b0;
  localparam logic       ACT_BEGIN           = 1'b1;
  localparam logic       MODE_FIXED          = 1'b0;
  localparam logic       MODE_CHUNKED        = 1'b1;
  localparam logic [7:0] CH_CR               = 8'h0d;
  localparam logic [7:0] CH_LF               = 8'h0a;
  localparam logic [7:0] CH_SPACE            = 8'h20;
  localparam logic [7:0] CH_TAB              = 8'h09;

  typedef enum logic [2:0] {
    PH_LEAD    = 3'd0,
    PH_DIGITS  = 3'd1,
    PH_SIZE_LF = 3'd2,
    PH_DATA    = 3'd3,
    PH_TAIL_CR = 3'd4,
    PH_TAIL_LF = 3'd5,
    PH_DONE    = 3'd6,
    PH_ERROR   = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    ST_BUSY     = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_ERROR    = 2'd2
  } status_e;

  // classified input item as it travels from front to back
  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_blank;
    logic       is_cr;
    logic       is_lf;
  } item_t;

  typedef struct packed {
    logic       body_valid;
    logic [7:0] body_byte;
    logic       body_last;
    logic [1:0] status;
  } result_t;

endpackage

`default_nettype wire

### sv/hbd_in_if.sv
// hbd_in_if: valid/ready channel carrying one input item of the deframer
// no dependencies
`default_nettype none

interface hbd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink (input valid, input action, input data_byte, output ready);
endinterface

`default_nettype wire

### sv/hbd_out_if.sv
// hbd_out_if: valid/ready channel carrying one result item of the deframer
// no dependencies
`default_nettype none

interface hbd_out_if;
  logic       valid;
  logic       ready;
  logic       body_valid;
  logic [7:0] body_byte;
  logic       body_last;
  logic [1:0] status;

  modport source (output valid, output body_valid, output body_byte, output body_last,
                  output status, input ready);
  modport sink (input valid, input body_valid, input body_byte, input body_last,
                input status, output ready);
endinterface

`default_nettype wire

### sv/hbd_front.sv
// hbd_front: accepts input items and classifies each byte for the back end
// depends on hbd_pkg and hbd_in_if
`default_nettype none

module hbd_front
  import hbd_pkg::*;
(
  hbd_in_if.sink in_i,
  input  wire    queue_full_i,
  output logic   push_o,
  output item_t  item_o
);

  logic [7:0] c;

  assign c          = in_i.data_byte;
  assign in_i.ready = !queue_full_i;
  assign push_o     = in_i.valid && !queue_full_i;

  always_comb begin
    item_o           = '0;
    item_o.action    = in_i.action;
    item_o.data_byte = c;
    item_o.is_blank  = (c == CH_SPACE) || (c == CH_TAB);
    item_o.is_cr     = (c == CH_CR);
    item_o.is_lf     = (c == CH_LF);
    if (c >= 8'h30 && c <= 8'h39) begin
      item_o.is_hex  = 1'b1;
      item_o.hex_val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      item_o.is_hex  = 1'b1;
      item_o.hex_val = c[3:0] + 4'd9;
    end
  end

endmodule

`default_nettype wire

### sv/hbd_queue.sv
// hbd_queue: short fifo of classified items between front and back
// depends on hbd_pkg
`default_nettype none

module hbd_queue
  import hbd_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   push_i,
  input  item_t item_i,
  output logic  full_o,
  input  wire   pop_i,
  output item_t item_o,
  output logic  empty_o
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  item_t            slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

### sv/hbd_back.sv
// hbd_back: framing state machine, configuration registers and output register
// depends on hbd_pkg and hbd_out_if
`default_nettype none

module hbd_back
  import hbd_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire                  cfg_index_i,
  input  wire [CFG_DATA_W-1:0] cfg_data_i,
  input  wire                  empty_i,
  input  item_t                item_i,
  output logic                 pop_o,
  hbd_out_if.source            out_o
);

  localparam int LB = LENGTH_BITS;

  logic              mode_q;
  logic [31:0]       exp_len_q;
  phase_e            phase_q, phase_d;
  logic [LB-1:0]     size_q, size_d;
  logic              saw_q, saw_d;
  logic [LB-1:0]     left_q, left_d;
  logic              final_q, final_d;
  logic [LB-1:0]     count_q, count_d;
  logic [LB-1:0]     limit;
  logic [LB-1:0]     count_inc;
  logic              res_valid, res_last;
  result_t           res_q, res_d;
  logic              out_valid_q;
  logic              take;

  assign limit     = LB'(exp_len_q);
  assign count_inc = count_q + 1'b1;
  assign take      = !empty_i && (!out_valid_q || out_o.ready);
  assign pop_o     = take;

  // next state
  always_comb begin
    phase_d = phase_q;
    size_d  = size_q;
    saw_d   = saw_q;
    left_d  = left_q;
    final_d = final_q;
    count_d = count_q;
    if (item_i.action == ACT_BEGIN) begin
      size_d  = '0;
      saw_d   = 1'b0;
      left_d  = '0;
      final_d = 1'b0;
      count_d = '0;
      phase_d = (mode_q == MODE_FIXED && limit == '0) ? PH_DONE : PH_LEAD;
    end else if (mode_q == MODE_FIXED) begin
      if (phase_q != PH_ERROR) begin
        if (phase_q == PH_DONE || count_q >= limit) begin
          phase_d = PH_ERROR;
        end else begin
          count_d = count_inc;
          if (count_inc == limit) begin
            phase_d = PH_DONE;
          end
        end
      end
    end else begin
      case (phase_q)
        PH_LEAD, PH_DIGITS: begin
          if (item_i.is_hex) begin
            if (size_q[LB-1 -: 4] != 4'd0) begin
              phase_d = PH_ERROR;
            end else begin
              size_d  = {size_q[LB-5:0], item_i.hex_val};
              saw_d   = 1'b1;
              phase_d = PH_DIGITS;
            end
          end else if (phase_q == PH_LEAD && item_i.is_blank) begin
            phase_d = PH_LEAD;
          end else if (item_i.is_cr && saw_q) begin
            phase_d = PH_SIZE_LF;
          end else begin
            phase_d = PH_ERROR;
          end
        end
        PH_SIZE_LF: begin
          if (!item_i.is_lf) begin
            phase_d = PH_ERROR;
          end else begin
            if (size_q == '0) begin
              final_d = 1'b1;
              phase_d = PH_TAIL_CR;
            end else begin
              left_d  = size_q;
              phase_d = PH_DATA;
            end
            size_d = '0;
            saw_d  = 1'b0;
          end
        end
        PH_DATA: begin
          if (left_q == '0) begin
            phase_d = item_i.is_cr ? PH_TAIL_LF : PH_ERROR;
          end else begin
            left_d  = left_q - 1'b1;
            count_d = count_inc;
            if (left_q == LB'(1)) begin
              phase_d = PH_TAIL_CR;
            end
          end
        end
        PH_TAIL_CR: phase_d = item_i.is_cr ? PH_TAIL_LF : PH_ERROR;
        PH_TAIL_LF: begin
          if (!item_i.is_lf) begin
            phase_d = PH_ERROR;
          end else begin
            phase_d = final_q ? PH_DONE : PH_LEAD;
          end
        end
        default: phase_d = PH_ERROR;
      endcase
    end
  end

  // result of the item in flight
  always_comb begin
    res_valid = 1'b0;
    res_last  = 1'b0;
    if (item_i.action == ACT_DATA) begin
      if (mode_q == MODE_FIXED) begin
        if (phase_q != PH_ERROR && phase_q != PH_DONE && count_q < limit) begin
          res_valid = 1'b1;
          res_last  = (count_inc == limit);
        end
      end else begin
        case (phase_q)
          PH_DATA:    res_valid = (left_q != '0);
          PH_TAIL_LF: res_last  = item_i.is_lf && final_q;
          default:    res_valid = 1'b0;
        endcase
      end
    end
    res_d            = '0;
    res_d.body_valid = res_valid;
    res_d.body_byte  = res_valid ? item_i.data_byte : 8'd0;
    res_d.body_last  = res_last;
    case (phase_d)
      PH_ERROR: res_d.status = ST_ERROR;
      PH_DONE:  res_d.status = ST_COMPLETE;
      default:  res_d.status = ST_BUSY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_FIXED;
      exp_len_q   <= '0;
      phase_q     <= PH_LEAD;
      size_q      <= '0;
      saw_q       <= 1'b0;
      left_q      <= '0;
      final_q     <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_FRAMING_MODE) begin
          mode_q <= cfg_data_i[0];
        end else begin
          exp_len_q <= cfg_data_i[31:0];
        end
      end
      if (take) begin
        phase_q <= phase_d;
        size_q  <= size_d;
        saw_q   <= saw_d;
        left_q  <= left_d;
        final_q <= final_d;
        count_q <= count_d;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.body_valid = res_q.body_valid;
  assign out_o.body_byte  = res_q.body_byte;
  assign out_o.body_last  = res_q.body_last;
  assign out_o.status     = res_q.status;

endmodule

`default_nettype wire

### sv/http_body_deframer.sv
// http_body_deframer: top level; front classifier, item queue and framing back end
// depends on hbd_pkg, hbd_in_if, hbd_out_if, hbd_front, hbd_queue, hbd_back
`default_nettype none

// Recovers the payload of an http request body, one byte per item, in fixed
// content-length mode or in chunked transfer mode, and returns one result item
// per input item with the payload byte, an end-of-body flag and a sticky
// status. A begin item clears the framing state. Throughput is one item per
// clock unless the output stalls; each item is held in the queue and then in the
// output register. The front classifies each byte and writes it into a two-entry
// queue; the back pops one item per cycle whenever its output register is free or
// being taken. Configuration may only be written while no item is in flight.

module http_body_deframer
  import hbd_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire                  cfg_index_i,
  input  wire [CFG_DATA_W-1:0] cfg_data_i,
  hbd_in_if.sink               in_i,
  hbd_out_if.source            out_o
);

  logic  push, pop, full, empty;
  item_t front_item, back_item;

  hbd_front u_front (
    .in_i         (in_i),
    .queue_full_i (full),
    .push_o       (push),
    .item_o       (front_item)
  );

  hbd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (back_item),
    .empty_o (empty)
  );

  hbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .empty_i     (empty),
    .item_i      (back_item),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

### test/tb_top.sv
// tb_top: self-checking testbench for http_body_deframer
// depends on hbd_pkg, hbd_in_if, hbd_out_if and the deframer rtl
// a directed table then random fixed-length and chunked bodies are checked against a predictor

module tb_top;
  import hbd_pkg::*;

  localparam int unsigned RAND_ITEMS = 650;
  localparam int unsigned CALM_AT    = 560;
  localparam int unsigned LIMIT      = 200000;
  localparam int unsigned MAX_REPORTS = 100;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct {
    bit                    is_cfg;
    logic                  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_val;
    in_item_t              item;
    bit                    typed;
    result_t               want;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic                  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  hbd_in_if  in_ch ();
  hbd_out_if out_ch ();

  http_body_deframer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // predictor state and register copies
  phase_e                 ph;
  logic [LENGTH_BITS-1:0] size_acc;
  logic [LENGTH_BITS-1:0] chunk_left;
  logic [LENGTH_BITS-1:0] payload_count;
  logic                   saw_digit;
  logic                   last_chunk;
  logic                   mode_r;
  logic [31:0]            length_r;

  result_t     awaited_results[$];
  dir_row_t    dir_rows[$];
  in_item_t    plan[$];
  int unsigned fails;
  int unsigned items_in, results_out, payload_seen, bodies_done, errors_seen, reg_writes;
  int unsigned rand_items;
  int unsigned cycles;
  bit          calm;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               awaited_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic result_t deframe_step(input logic act, input logic [7:0] c);
    result_t    r;
    logic [7:0] nib;
    bit         is_hex;
    r = '0;
    is_hex = 1'b1;
    if (c >= "0" && c <= "9") nib = c - "0";
    else if (c >= "a" && c <= "f") nib = c - "a" + 8'd10;
    else if (c >= "A" && c <= "F") nib = c - "A" + 8'd10;
    else begin
      is_hex = 1'b0;
      nib = '0;
    end
    if (act == ACT_BEGIN) begin
      ph = PH_LEAD;
      size_acc = '0;
      saw_digit = 1'b0;
      chunk_left = '0;
      last_chunk = 1'b0;
      payload_count = '0;
      if (mode_r == MODE_FIXED && length_r == 0) ph = PH_DONE;
    end else if (mode_r == MODE_FIXED) begin
      if (ph != PH_ERROR) begin
        if (ph == PH_DONE || payload_count >= length_r) ph = PH_ERROR;
        else begin
          r.body_valid = 1'b1;
          payload_count = payload_count + 1;
          if (payload_count == length_r) begin
            ph = PH_DONE;
            r.body_last = 1'b1;
          end
        end
      end
    end else begin
      case (ph)
        PH_LEAD, PH_DIGITS: begin
          if (is_hex) begin
            if (size_acc[LENGTH_BITS-1 -: 4] != 0) ph = PH_ERROR;
            else begin
              size_acc = {size_acc[LENGTH_BITS-5:0], nib[3:0]};
              saw_digit = 1'b1;
              ph = PH_DIGITS;
            end
          end else if (ph == PH_LEAD && (c == CH_SPACE || c == CH_TAB)) begin
          end else if (c == CH_CR && saw_digit) ph = PH_SIZE_LF;
          else ph = PH_ERROR;
        end
        PH_SIZE_LF: begin
          if (c != CH_LF) ph = PH_ERROR;
          else begin
            if (size_acc == 0) begin
              last_chunk = 1'b1;
              ph = PH_TAIL_CR;
            end else begin
              chunk_left = size_acc;
              ph = PH_DATA;
            end
            size_acc = '0;
            saw_digit = 1'b0;
          end
        end
        PH_DATA: begin
          if (chunk_left == 0) ph = (c == CH_CR) ? PH_TAIL_LF : PH_ERROR;
          else begin
            r.body_valid = 1'b1;
            chunk_left = chunk_left - 1;
            payload_count = payload_count + 1;
            if (chunk_left == 0) ph = PH_TAIL_CR;
          end
        end
        PH_TAIL_CR: ph = (c == CH_CR) ? PH_TAIL_LF : PH_ERROR;
        PH_TAIL_LF: begin
          if (c != CH_LF) ph = PH_ERROR;
          else if (last_chunk) begin
            ph = PH_DONE;
            r.body_last = 1'b1;
          end else ph = PH_LEAD;
        end
        default: ph = PH_ERROR;
      endcase
    end
    r.body_byte = r.body_valid ? c : 8'h00;
    if (ph == PH_ERROR) r.status = ST_ERROR;
    else if (ph == PH_DONE) r.status = ST_COMPLETE;
    else r.status = ST_BUSY;
    return r;
  endfunction

  task automatic send_item(input in_item_t it, input bit typed, input result_t want);
    result_t r;
    if (!calm && $urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 7)) begin
        @(negedge clk_i);
        in_ch.valid <= 1'b0;
      end
    end
    @(negedge clk_i);
    in_ch.valid     <= 1'b1;
    in_ch.action    <= it.action;
    in_ch.data_byte <= it.data_byte;
    do @(posedge clk_i); while (!in_ch.ready);
    r = deframe_step(it.action, it.data_byte);
    awaited_results.push_back(typed ? want : r);
    items_in++;
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    if (idx == CFG_FRAMING_MODE) mode_r = val[0];
    else length_r = val;
    reg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      fails++;
      if (fails <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // directed table builders
  function automatic void add_cfg(input logic idx, input logic [CFG_DATA_W-1:0] val);
    dir_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.cfg_idx = idx;
    row.cfg_val = val;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_item(input logic act, input logic [7:0] b);
    dir_row_t row;
    row = '{default: '0};
    row.item = '{act, b};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_typed(input logic act, input logic [7:0] b, input logic bv,
                                    input logic [7:0] bb, input logic bl, input status_e st);
    dir_row_t row;
    row = '{default: '0};
    row.item = '{act, b};
    row.typed = 1'b1;
    row.want = '{bv, bb, bl, st};
    dir_rows.push_back(row);
  endfunction

  // random body planners
  function automatic void plan_byte(input logic [7:0] b);
    plan.push_back('{ACT_DATA, b});
  endfunction

  function automatic void plan_begin();
    plan.push_back('{ACT_BEGIN, 8'($urandom_range(0, 255))});
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return "0" + n;
    return ($urandom_range(0, 1) ? "A" : "a") + n - 8'd10;
  endfunction

  function automatic void plan_size_line(input logic [31:0] sz);
    int nd;
    repeat ($urandom_range(0, 2)) plan_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    repeat ($urandom_range(0, 1)) plan_byte("0");
    nd = 1;
    while (nd < 8 && (sz >> (4 * nd)) != 0) nd++;
    for (int i = nd - 1; i >= 0; i--) plan_byte(hex_char(sz[4*i +: 4]));
    plan_byte(CH_CR);
    plan_byte(CH_LF);
  endfunction

  function automatic void plan_fixed();
    int unsigned n;
    if ($urandom_range(0, 9) != 0) plan_begin();
    n = (length_r <= 40) ? length_r : $urandom_range(1, 30);
    case ($urandom_range(0, 7))
      0: n += $urandom_range(1, 2);
      1: if (n > 0) n--;
      default: begin end
    endcase
    repeat (n) plan_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic void plan_chunked();
    int unsigned sz;
    if ($urandom_range(0, 9) != 0) plan_begin();
    repeat ($urandom_range(0, 3)) begin
      sz = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      plan_size_line(sz);
      repeat (sz) plan_byte(8'($urandom_range(0, 255)));
      plan_byte(CH_CR);
      plan_byte(CH_LF);
    end
    // size line at or past the counter width
    if ($urandom_range(0, 12) == 0) begin
      plan_byte(hex_char(4'($urandom_range(1, 15))));
      repeat ($urandom_range(7, 8)) plan_byte(hex_char(4'($urandom_range(0, 15))));
      plan_byte(CH_CR);
      plan_byte(CH_LF);
      repeat ($urandom_range(1, 4)) plan_byte(8'($urandom_range(0, 255)));
    end
    plan_size_line(0);
    plan_byte(CH_CR);
    plan_byte(CH_LF);
  endfunction

  function automatic logic [7:0] bad_char();
    case ($urandom_range(0, 6))
      0: return ";";
      1: return CH_SPACE;
      2: return CH_TAB;
      3: return "g";
      4: return CH_CR;
      5: return CH_LF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [31:0] pick_length();
    case ($urandom_range(0, 15))
      0, 1:    return 32'd0;
      2:       return 32'hFFFF_FFFF;
      3:       return $urandom();
      default: return $urandom_range(1, 24);
    endcase
  endfunction

  initial begin : sink_pacing
    int unsigned hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!calm && hold == 0 && $urandom_range(0, 7) == 0) hold = $urandom_range(1, 7);
      if (hold != 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else out_ch.ready <= 1'b1;
    end
  end

  initial begin : result_monitor
    result_t got, want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        got = '{out_ch.body_valid, out_ch.body_byte, out_ch.body_last, out_ch.status};
        results_out++;
        if (got.body_valid) payload_seen++;
        if (got.body_last) bodies_done++;
        if (got.status == ST_ERROR) errors_seen++;
        if (awaited_results.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t: unexpected result, actual %0h", $time, got);
        end else begin
          want = awaited_results.pop_front();
          check_field("body_valid", want.body_valid, got.body_valid);
          check_field("body_byte", want.body_byte, got.body_byte);
          check_field("body_last", want.body_last, got.body_last);
          check_field("status", want.status, got.status);
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned pick;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = CFG_FRAMING_MODE;
    cfg_data_i      = '0;
    in_ch.valid     = 1'b0;
    in_ch.action    = ACT_DATA;
    in_ch.data_byte = '0;
    mode_r          = MODE_FIXED;
    length_r        = '0;
    ph              = PH_LEAD;
    size_acc        = '0;
    chunk_left      = '0;
    payload_count   = '0;
    saw_digit       = 1'b0;
    last_chunk      = 1'b0;
    calm            = 1'b0;

    // fixed mode, length zero, straight out of reset
    add_typed(ACT_DATA, 8'h00, 1'b0, 8'h00, 1'b0, ST_ERROR);
    add_typed(ACT_BEGIN, 8'hFF, 1'b0, 8'h00, 1'b0, ST_COMPLETE);
    add_typed(ACT_DATA, 8'hFF, 1'b0, 8'h00, 1'b0, ST_ERROR);
    add_cfg(CFG_FRAMING_MODE, MODE_FIXED);
    add_cfg(CFG_EXPECTED_LENGTH, 32'd2);
    add_typed(ACT_BEGIN, 8'h00, 1'b0, 8'h00, 1'b0, ST_BUSY);
    add_typed(ACT_DATA, 8'hA5, 1'b1, 8'hA5, 1'b0, ST_BUSY);
    add_typed(ACT_DATA, 8'h5A, 1'b1, 8'h5A, 1'b1, ST_COMPLETE);
    add_typed(ACT_DATA, 8'h00, 1'b0, 8'h00, 1'b0, ST_ERROR);
    add_typed(ACT_DATA, 8'h11, 1'b0, 8'h00, 1'b0, ST_ERROR);
    add_cfg(CFG_EXPECTED_LENGTH, 32'hFFFF_FFFF);
    add_typed(ACT_BEGIN, 8'h00, 1'b0, 8'h00, 1'b0, ST_BUSY);
    add_typed(ACT_DATA, 8'hFF, 1'b1, 8'hFF, 1'b0, ST_BUSY);
    // chunked: blanks, one-byte chunk carrying a cr, then the zero chunk
    add_cfg(CFG_FRAMING_MODE, MODE_CHUNKED);
    add_typed(ACT_BEGIN, 8'h00, 1'b0, 8'h00, 1'b0, ST_BUSY);
    add_item(ACT_DATA, CH_TAB);
    add_item(ACT_DATA, CH_SPACE);
    add_item(ACT_DATA, "1");
    add_item(ACT_DATA, CH_CR);
    add_item(ACT_DATA, CH_LF);
    add_item(ACT_DATA, CH_CR);
    add_item(ACT_DATA, CH_CR);
    add_item(ACT_DATA, CH_LF);
    add_item(ACT_DATA, "0");
    add_item(ACT_DATA, CH_CR);
    add_item(ACT_DATA, CH_LF);
    add_item(ACT_DATA, CH_CR);
    add_typed(ACT_DATA, CH_LF, 1'b0, 8'h00, 1'b1, ST_COMPLETE);

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
      else send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    end

    while (rand_items < RAND_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 3);
        if (pick != 1) write_reg(CFG_FRAMING_MODE, $urandom_range(0, 1));
        if (pick != 0) write_reg(CFG_EXPECTED_LENGTH, pick_length());
      end
      plan.delete();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(5, 15))
          plan.push_back('{($urandom_range(0, 7) == 0) ? ACT_BEGIN : ACT_DATA,
                           8'($urandom_range(0, 255))});
      end else if (mode_r == MODE_CHUNKED) plan_chunked();
      else plan_fixed();
      if ($urandom_range(0, 5) == 0 && plan.size() > 1)
        plan[$urandom_range(1, plan.size() - 1)].data_byte = bad_char();
      if ($urandom_range(0, 7) == 0) plan_byte(8'($urandom_range(0, 255)));
      foreach (plan[i]) begin
        send_item(plan[i], 1'b0, '0);
        rand_items++;
        calm = (rand_items >= CALM_AT);
      end
    end

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d items in, %0d results, %0d payload bytes, %0d register writes",
             items_in, results_out, payload_seen, reg_writes);
    $display("bodies completed %0d, results with framing error %0d, mismatches %0d",
             bodies_done, errors_seen, fails);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
